// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the hexagon hit-test RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define PHCR_CHECK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle
`define PHCR_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/phcr_pkg.sv =====
// Package for the pixel-to-hex cube rounding block: widths, constants, register codes.
// No dependencies; imported by every other file of the block but assert_macros.svh.
`default_nettype none

package phcr_pkg;

    // Field widths
    localparam int PIXW      = 16;  // pixel coordinate
    localparam int OFSW      = 21;  // origin and offset registers
    localparam int SIZEW     = 12;  // hex radius register
    localparam int OUTW      = 19;  // cube coordinate
    localparam int XMW       = 22;  // magnitude of the shifted coordinate
    localparam int CFG_IDXW  = 3;
    localparam int CFG_DATAW = 21;

    // Fixed-point constants, 16 fraction bits
    localparam int CONST_BITS = 16;
    localparam logic [15:0] K_SQRT3_3    = 16'd37837;
    localparam logic [15:0] K_THIRD      = 16'd21845;
    localparam logic [15:0] K_TWO_THIRDS = 16'd43691;

    localparam int FRAC_BITS_DEF = 16;
    localparam logic [SIZEW-1:0] RADIUS_RST = SIZEW'(512);

    // Register indexes
    typedef enum logic [CFG_IDXW-1:0] {
        CFG_RADIUS       = 3'd0,
        CFG_MAP_ORIGIN_X = 3'd1,
        CFG_MAP_ORIGIN_Y = 3'd2,
        CFG_MAP_OFFSET_X = 3'd3,
        CFG_MAP_OFFSET_Y = 3'd4
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== rtl/phcr_ifs.sv =====
// Channel interfaces of the hexagon hit-test block: pixel in, cube out, register writes.
// Depends on phcr_pkg.
`default_nettype none

interface phcr_pix_if import phcr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [PIXW-1:0] pixel_x;
    logic signed [PIXW-1:0] pixel_y;
    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface phcr_cube_if import phcr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [OUTW-1:0] cube_q;
    logic signed [OUTW-1:0] cube_r;
    logic signed [OUTW-1:0] cube_s;
    modport source (output valid, output cube_q, output cube_r, output cube_s, input ready);
    modport sink   (input valid, input cube_q, input cube_r, input cube_s, output ready);
endinterface

interface phcr_cfg_if import phcr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDXW-1:0]  index;
    logic [CFG_DATAW-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/phcr_div_cell.sv =====
// One cell of the divider chain: one restoring quotient bit for the x and y lanes.
// Depends on phcr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module phcr_div_cell import phcr_pkg::*; #(
    parameter int MW = XMW + FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [MW+SIZEW:0]     i_lane_x,
    input  wire logic [MW+SIZEW:0]     i_lane_y,
    input  wire logic [SIZEW-1:0]      i_div,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [MW+SIZEW:0]          o_lane_x,
    output logic [MW+SIZEW:0]          o_lane_y,
    output logic [SIZEW-1:0]           o_div
);
    // Lane layout: {negative, remainder, dividend/quotient shift word}
    localparam int LNW = MW + SIZEW + 1;

    logic                r_v;
    logic [LNW-1:0]      r_x, r_y;
    logic [SIZEW-1:0]    r_d;
    logic [LNW-1:0]      n_x, n_y;

    // Shift in the next dividend bit, subtract when the divisor fits
    function automatic logic [LNW-1:0] f_step(input logic [LNW-1:0] lane,
                                              input logic [SIZEW-1:0] d);
        logic [SIZEW:0]   trial;
        logic             ge;
        logic [SIZEW-1:0] rem;
        logic [MW-1:0]    mq;
        trial = {lane[MW+SIZEW-1:MW], lane[MW-1]};
        ge    = (trial >= {1'b0, d});
        rem   = ge ? SIZEW'(trial - {1'b0, d}) : trial[SIZEW-1:0];
        mq    = {lane[MW-2:0], ge};
        return {lane[LNW-1], rem, mq};
    endfunction

    assign n_x     = f_step(i_lane_x, i_div);
    assign n_y     = f_step(i_lane_y, i_div);
    assign o_ready = !r_v || i_ready;

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x <= n_x;
            r_y <= n_y;
            r_d <= i_div;
        end
    end

    assign o_valid  = r_v;
    assign o_lane_x = r_x;
    assign o_lane_y = r_y;
    assign o_div    = r_d;

    `PHCR_CHECK(a_rem_below_div, i_clk, i_rst_n, !r_v || (r_x[MW+SIZEW-1:MW] < r_d && r_y[MW+SIZEW-1:MW] < r_d), "remainder not below divisor")
    `PHCR_CHECK_NEXT(a_stall_holds, i_clk, i_rst_n, r_v && !i_ready, r_v, "stalled cell lost its transaction")

endmodule

`default_nettype wire

// ===== rtl/phcr_round.sv =====
// Back end: signs the quotients, maps to axial coordinates, cube-rounds and saturates.
// Depends on phcr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module phcr_round import phcr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [XMW+FRAC_BITS+SIZEW:0]  i_lane_x,
    input  wire logic [XMW+FRAC_BITS+SIZEW:0]  i_lane_y,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [OUTW-1:0]             o_cube_q,
    output logic signed [OUTW-1:0]             o_cube_r,
    output logic signed [OUTW-1:0]             o_cube_s
);
    localparam int MW  = XMW + FRAC_BITS;
    localparam int LNW = MW + SIZEW + 1;
    localparam int PW  = MW + 1;           // signed quotient
    localparam int LW  = (PW + 1) / 2;     // low part, unsigned
    localparam int HW  = PW - LW;          // high part, signed
    localparam int PLW = LW + 18;
    localparam int PHW = HW + 17;
    localparam int AW  = PW + 18;
    localparam int VW  = PW + 2;           // axial value, FRAC_BITS fraction bits
    localparam int RW  = VW + 2 - FRAC_BITS;
    localparam int EW  = FRAC_BITS + 1;
    localparam int NS  = 7;

    localparam logic signed [16:0] C_SQ = $signed({1'b0, K_SQRT3_3});
    localparam logic signed [16:0] C_TH = $signed({1'b0, K_THIRD});
    localparam logic signed [16:0] C_TT = $signed({1'b0, K_TWO_THIRDS});

    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;
    logic [NS-1:0] w_en;

    // Ready chain: a stage takes a transaction when it is empty or drains
    always_comb begin
        w_rdy[NS] = i_ready;
        for (int k = 0; k < NS; k++) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end
    assign w_en    = w_rdy[NS-1:0];
    assign o_ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Round half away from zero
    function automatic logic signed [RW-1:0] f_round(input logic signed [VW-1:0] v);
        logic [VW-1:0]  mag;
        logic [VW:0]    sum;
        logic [RW-2:0]  t;
        mag = v[VW-1] ? VW'(-v) : VW'(v);
        sum = (VW+1)'(mag) + ((VW+1)'(1) << (FRAC_BITS - 1));
        t   = sum[VW:FRAC_BITS];
        return v[VW-1] ? -$signed({1'b0, t}) : $signed({1'b0, t});
    endfunction

    // Rounding error |rounded * 2^F - v|
    function automatic logic [EW-1:0] f_err(input logic signed [RW-1:0] rv,
                                            input logic signed [VW-1:0] v);
        logic signed [VW+1:0] d;
        logic [VW+1:0]        a;
        d = ((VW+2)'(rv) <<< FRAC_BITS) - (VW+2)'(v);
        a = d[VW+1] ? (VW+2)'(-d) : (VW+2)'(d);
        return a[EW-1:0];
    endfunction

    // Clamp to the output range
    function automatic logic signed [OUTW-1:0] f_sat(input logic signed [RW:0] v);
        logic signed [RW:0] hi, lo;
        hi = (RW+1)'((1 << (OUTW - 1)) - 1);
        lo = -((RW+1)'(1 << (OUTW - 1)));
        if (v > hi) begin
            return OUTW'(hi);
        end else if (v < lo) begin
            return OUTW'(lo);
        end
        return OUTW'(v);
    endfunction

    // Stage 1: apply the sign to the quotients
    logic signed [PW-1:0] r_px, r_py;
    always_ff @(posedge i_clk) begin
        if (w_en[0] && i_valid) begin
            r_px <= i_lane_x[LNW-1] ? -$signed({1'b0, i_lane_x[MW-1:0]})
                                    : $signed({1'b0, i_lane_x[MW-1:0]});
            r_py <= i_lane_y[LNW-1] ? -$signed({1'b0, i_lane_y[MW-1:0]})
                                    : $signed({1'b0, i_lane_y[MW-1:0]});
        end
    end

    // Stage 2: partial products on the low and high halves
    logic signed [PLW-1:0] r_qxl, r_qyl, r_ryl;
    logic signed [PHW-1:0] r_qxh, r_qyh, r_ryh;
    always_ff @(posedge i_clk) begin
        if (w_en[1] && r_v[0]) begin
            r_qxl <= C_SQ * $signed({1'b0, r_px[LW-1:0]});
            r_qyl <= C_TH * $signed({1'b0, r_py[LW-1:0]});
            r_ryl <= C_TT * $signed({1'b0, r_py[LW-1:0]});
            r_qxh <= C_SQ * $signed(r_px[PW-1:LW]);
            r_qyh <= C_TH * $signed(r_py[PW-1:LW]);
            r_ryh <= C_TT * $signed(r_py[PW-1:LW]);
        end
    end

    // Stage 3: combine partial products and floor by the constant scale
    logic signed [AW-1:0] w_aq, w_ar;
    logic signed [VW-1:0] r_qf3, r_rf3;
    assign w_aq = (AW'(r_qxh) <<< LW) + AW'(r_qxl) - (AW'(r_qyh) <<< LW) - AW'(r_qyl);
    assign w_ar = (AW'(r_ryh) <<< LW) + AW'(r_ryl);
    always_ff @(posedge i_clk) begin
        if (w_en[2] && r_v[1]) begin
            r_qf3 <= VW'(w_aq >>> CONST_BITS);
            r_rf3 <= VW'(w_ar >>> CONST_BITS);
        end
    end

    // Stage 4: third cube component
    logic signed [VW-1:0] r_qf, r_rf, r_sf;
    always_ff @(posedge i_clk) begin
        if (w_en[3] && r_v[2]) begin
            r_qf <= r_qf3;
            r_rf <= r_rf3;
            r_sf <= -r_qf3 - r_rf3;
        end
    end

    // Stage 5: round each component
    logic signed [VW-1:0] r_qf5, r_rf5, r_sf5;
    logic signed [RW-1:0] r_qr5, r_rr5, r_sr5;
    always_ff @(posedge i_clk) begin
        if (w_en[4] && r_v[3]) begin
            r_qf5 <= r_qf;
            r_rf5 <= r_rf;
            r_sf5 <= r_sf;
            r_qr5 <= f_round(r_qf);
            r_rr5 <= f_round(r_rf);
            r_sr5 <= f_round(r_sf);
        end
    end

    // Stage 6: rounding errors
    logic signed [RW-1:0] r_qr, r_rr, r_sr;
    logic [EW-1:0]        r_qd, r_rd, r_sd;
    always_ff @(posedge i_clk) begin
        if (w_en[5] && r_v[4]) begin
            r_qr <= r_qr5;
            r_rr <= r_rr5;
            r_sr <= r_sr5;
            r_qd <= f_err(r_qr5, r_qf5);
            r_rd <= f_err(r_rr5, r_rf5);
            r_sd <= f_err(r_sr5, r_sf5);
        end
    end

    // Stage 7: rebuild the worst component, then saturate
    logic signed [RW:0] w_q, w_r, w_s;
    logic signed [RW+2:0] w_sum;
    always_comb begin
        w_q = (RW+1)'(r_qr);
        w_r = (RW+1)'(r_rr);
        w_s = (RW+1)'(r_sr);
        priority if (r_qd > r_rd && r_qd > r_sd) begin
            w_q = -(RW+1)'(r_rr) - (RW+1)'(r_sr);
        end else if (r_rd > r_sd) begin
            w_r = -(RW+1)'(r_qr) - (RW+1)'(r_sr);
        end else begin
            w_s = -(RW+1)'(r_qr) - (RW+1)'(r_rr);
        end
    end
    assign w_sum = (RW+3)'(w_q) + (RW+3)'(w_r) + (RW+3)'(w_s);

    logic signed [OUTW-1:0] r_oq, r_or, r_os;
    always_ff @(posedge i_clk) begin
        if (w_en[6] && r_v[5]) begin
            r_oq <= f_sat(w_q);
            r_or <= f_sat(w_r);
            r_os <= f_sat(w_s);
        end
    end

    assign o_valid  = r_v[NS-1];
    assign o_cube_q = r_oq;
    assign o_cube_r = r_or;
    assign o_cube_s = r_os;

    `PHCR_CHECK(a_cube_sum_zero, i_clk, i_rst_n, !r_v[5] || w_sum == '0, "rebuilt cube does not sum to zero")

endmodule

`default_nettype wire

// ===== rtl/pixel_to_hex_cube_round.sv =====
// Pipeline: an entry stage, one divider cell per quotient bit and seven rounding stages.
// Throughput: one pixel per cycle while the output is not stalled; every stage holds its
// own transaction, so bubbles fill.
// Reset (synchronous, active low) empties the pipeline and loads register defaults:
// hex radius 512, origins and offsets 0. Configuration writes are taken in any cycle.
`default_nettype none
`include "assert_macros.svh"

module pixel_to_hex_cube_round import phcr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    phcr_cfg_if.sink          i_cfg,
    phcr_pix_if.sink          i_pix,
    phcr_cube_if.source       o_cube
);
    localparam int MW  = XMW + FRAC_BITS;
    localparam int LNW = MW + SIZEW + 1;
    localparam int XW  = XMW + 1;

    // Configuration registers
    logic [SIZEW-1:0]       r_radius;
    logic signed [OFSW-1:0] r_org_x, r_org_y, r_ofs_x, r_ofs_y;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= RADIUS_RST;
            r_org_x    <= '0;
            r_org_y    <= '0;
            r_ofs_x    <= '0;
            r_ofs_y    <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_RADIUS:       r_radius   <= i_cfg.data[SIZEW-1:0];
                CFG_MAP_ORIGIN_X: r_org_x    <= $signed(i_cfg.data[OFSW-1:0]);
                CFG_MAP_ORIGIN_Y: r_org_y    <= $signed(i_cfg.data[OFSW-1:0]);
                CFG_MAP_OFFSET_X: r_ofs_x    <= $signed(i_cfg.data[OFSW-1:0]);
                CFG_MAP_OFFSET_Y: r_ofs_y    <= $signed(i_cfg.data[OFSW-1:0]);
                default: ;
            endcase
        end
    end

    // Entry stage: shift into map space, split sign and magnitude
    logic signed [XW-1:0] w_x, w_y;
    logic [XMW-1:0]       w_mx, w_my;
    logic [SIZEW-1:0]     w_div;

    assign w_x = (XW'(i_pix.pixel_x) <<< 4) + XW'(r_ofs_x) - XW'(r_org_x);
    assign w_y = (XW'(i_pix.pixel_y) <<< 4) + XW'(r_ofs_y) - XW'(r_org_y);
    assign w_mx = w_x[XW-1] ? XMW'(-w_x) : XMW'(w_x);
    assign w_my = w_y[XW-1] ? XMW'(-w_y) : XMW'(w_y);
    assign w_div = (r_radius == '0) ? SIZEW'(1) : r_radius;

    logic                 w_v   [MW+1];
    logic                 w_rdy [MW+1];
    logic [LNW-1:0]       w_lx  [MW+1];
    logic [LNW-1:0]       w_ly  [MW+1];
    logic [SIZEW-1:0]     w_d   [MW+1];

    logic                 r_v0;
    logic [LNW-1:0]       r_lx0, r_ly0;
    logic [SIZEW-1:0]     r_d0;

    assign i_pix.ready = !r_v0 || w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_pix.ready) begin
            r_v0 <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.ready && i_pix.valid) begin
            r_lx0 <= {w_x[XW-1], {SIZEW{1'b0}}, w_mx, {FRAC_BITS{1'b0}}};
            r_ly0 <= {w_y[XW-1], {SIZEW{1'b0}}, w_my, {FRAC_BITS{1'b0}}};
            r_d0  <= w_div;
        end
    end

    assign w_v[0]  = r_v0;
    assign w_lx[0] = r_lx0;
    assign w_ly[0] = r_ly0;
    assign w_d[0]  = r_d0;

    // Divider chain: one cell per quotient bit
    for (genvar k = 0; k < MW; k++) begin : g_cell
        phcr_div_cell #(.MW(MW)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (w_v[k]),
            .o_ready  (w_rdy[k]),
            .i_lane_x (w_lx[k]),
            .i_lane_y (w_ly[k]),
            .i_div    (w_d[k]),
            .o_valid  (w_v[k+1]),
            .i_ready  (w_rdy[k+1]),
            .o_lane_x (w_lx[k+1]),
            .o_lane_y (w_ly[k+1]),
            .o_div    (w_d[k+1])
        );
    end

    // Axial mapping, cube rounding and output register
    logic w_d_last_used;
    assign w_d_last_used = |w_d[MW];

    phcr_round #(.FRAC_BITS(FRAC_BITS)) u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_v[MW] && w_d_last_used),
        .o_ready  (w_rdy[MW]),
        .i_lane_x (w_lx[MW]),
        .i_lane_y (w_ly[MW]),
        .o_valid  (o_cube.valid),
        .i_ready  (o_cube.ready),
        .o_cube_q (o_cube.cube_q),
        .o_cube_r (o_cube.cube_r),
        .o_cube_s (o_cube.cube_s)
    );

    `PHCR_CHECK(a_div_nonzero, i_clk, i_rst_n, !r_v0 || r_d0 != '0, "divisor entered the chain as zero")
    `PHCR_CHECK(a_last_div_nonzero, i_clk, i_rst_n, !w_v[MW] || w_d_last_used, "divisor lost along the chain")

endmodule

`default_nettype wire

// ===== verif/tb_pixel_to_hex_cube_round.sv =====
// Testbench for pixel_to_hex_cube_round: drives pixel transactions with random gaps,
// predicts cube coordinates in fixed point, and compares each result in order.
// Depends on phcr_pkg, phcr_ifs and the block RTL.
`default_nettype none

module tb_pixel_to_hex_cube_round;
    import phcr_pkg::*;

    typedef struct packed {
        logic signed [PIXW-1:0] x;
        logic signed [PIXW-1:0] y;
    } t_pixel;

    typedef struct packed {
        logic signed [OUTW-1:0] q;
        logic signed [OUTW-1:0] r;
        logic signed [OUTW-1:0] s;
    } t_cube;

    localparam int LATENCY  = FRAC_BITS_DEF + 30;
    localparam int WDOG_MAX = 20000;

    logic i_clk;
    logic i_rst_n;

    phcr_cfg_if  cfg_ch ();
    phcr_pix_if  pix_ch ();
    phcr_cube_if cube_ch ();

    pixel_to_hex_cube_round dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch.sink),
        .i_pix   (pix_ch.sink),
        .o_cube  (cube_ch.source)
    );

    // Predictor copy of the registers
    logic        [SIZEW-1:0] radius_m;
    logic signed [OFSW-1:0]  origin_x_m, origin_y_m, offset_x_m, offset_y_m;

    t_pixel pending_pixels[$];
    t_cube  expected_cubes[$];

    int  mismatch_cnt = 0;
    int  accepted_in  = 0;
    int  accepted_out = 0;
    int  idle_cycles  = 0;
    int  in_gap       = 0;
    int  out_gap      = 0;
    int  holdoff_left = 0;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Round half away from zero, whole units
    function automatic longint round_away(longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 <<< (FRAC_BITS_DEF - 1))) >>> FRAC_BITS_DEF;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint floor16(longint v);
        return v >>> CONST_BITS;  // arithmetic shift is floor
    endfunction

    function automatic logic signed [OUTW-1:0] clamp_out(longint v);
        if (v > 262143) v = 262143;
        if (v < -262144) v = -262144;
        return v[OUTW-1:0];
    endfunction

    function automatic t_cube hex_of_pixel(t_pixel p);
        longint size, xs, ys, px, py, qf, rf, sf, qr, rr, sr, qd, rd, sd;
        t_cube c;
        size = radius_m;
        if (size == 0) size = 1;
        xs = longint'(p.x) * 16 + longint'(offset_x_m) - longint'(origin_x_m);
        ys = longint'(p.y) * 16 + longint'(offset_y_m) - longint'(origin_y_m);
        px = (xs * (64'sd1 <<< FRAC_BITS_DEF)) / size;
        py = (ys * (64'sd1 <<< FRAC_BITS_DEF)) / size;
        qf = floor16(longint'(K_SQRT3_3) * px - longint'(K_THIRD) * py);
        rf = floor16(longint'(K_TWO_THIRDS) * py);
        sf = -qf - rf;
        qr = round_away(qf);
        rr = round_away(rf);
        sr = round_away(sf);
        qd = qr * (64'sd1 <<< FRAC_BITS_DEF) - qf; if (qd < 0) qd = -qd;
        rd = rr * (64'sd1 <<< FRAC_BITS_DEF) - rf; if (rd < 0) rd = -rd;
        sd = sr * (64'sd1 <<< FRAC_BITS_DEF) - sf; if (sd < 0) sd = -sd;
        if (qd > rd && qd > sd) qr = -rr - sr;
        else if (rd > sd) rr = -qr - sr;
        else sr = -qr - rr;
        c.q = clamp_out(qr);
        c.r = clamp_out(rr);
        c.s = clamp_out(sr);
        return c;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH result %0d %s: got %0d expected %0d", accepted_out, what, got, want);
        mismatch_cnt++;
    endtask

    // Pixel driver: pop queued items, hold valid until accepted, random gap after
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
        end else if (pix_ch.valid && pix_ch.ready) begin
            expected_cubes.push_back(hex_of_pixel({pix_ch.pixel_x, pix_ch.pixel_y}));
            accepted_in++;
            in_gap = $urandom_range(0, 13) * ($urandom_range(0, 3) == 0 ? 0 : 1);
            if (in_gap == 0 && pending_pixels.size() > 0) begin
                {pix_ch.pixel_x, pix_ch.pixel_y} <= pending_pixels.pop_front();
            end else begin
                pix_ch.valid <= 1'b0;
            end
        end else if (!pix_ch.valid) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (pending_pixels.size() > 0) begin
                {pix_ch.pixel_x, pix_ch.pixel_y} <= pending_pixels.pop_front();
                pix_ch.valid <= 1'b1;
            end
        end
    end

    // Cube monitor: check accepted results, draw a stall per result, long hold-off on demand
    always @(posedge i_clk) begin
        t_cube want;
        if (!i_rst_n) begin
            cube_ch.ready <= 1'b0;
        end else begin
            if (cube_ch.valid && cube_ch.ready) begin
                accepted_out++;
                if (expected_cubes.size() == 0) begin
                    $display("MISMATCH unexpected result %0d", accepted_out);
                    mismatch_cnt++;
                end else begin
                    want = expected_cubes.pop_front();
                    if (cube_ch.cube_q !== want.q) report_mismatch("q", cube_ch.cube_q, want.q);
                    if (cube_ch.cube_r !== want.r) report_mismatch("r", cube_ch.cube_r, want.r);
                    if (cube_ch.cube_s !== want.s) report_mismatch("s", cube_ch.cube_s, want.s);
                end
                out_gap = $urandom_range(0, 13) * ($urandom_range(0, 2) == 0 ? 0 : 1);
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                cube_ch.ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                cube_ch.ready <= 1'b0;
            end else begin
                cube_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles without any transaction
    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (cube_ch.valid && cube_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG_MAX) begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("tb_pixel_to_hex_cube_round failed");
            $finish;
        end
    end

    // Register write, one transaction, predictor updated at acceptance
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATAW-1:0] value);
        @(posedge i_clk);
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_RADIUS:       radius_m   = value[SIZEW-1:0];
            CFG_MAP_ORIGIN_X: origin_x_m = value;
            CFG_MAP_ORIGIN_Y: origin_y_m = value;
            CFG_MAP_OFFSET_X: offset_x_m = value;
            CFG_MAP_OFFSET_Y: offset_y_m = value;
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_all(logic [SIZEW-1:0] sz, logic [OFSW-1:0] ox, logic [OFSW-1:0] oy,
                             logic [OFSW-1:0] fx, logic [OFSW-1:0] fy);
        write_reg(CFG_RADIUS, CFG_DATAW'(sz));
        write_reg(CFG_MAP_ORIGIN_X, ox);
        write_reg(CFG_MAP_ORIGIN_Y, oy);
        write_reg(CFG_MAP_OFFSET_X, fx);
        write_reg(CFG_MAP_OFFSET_Y, fy);
    endtask

    // Wait for the pipeline to drain
    task automatic drain();
        wait (pending_pixels.size() == 0 && !pix_ch.valid && expected_cubes.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Pixel fully random or within a small centred range, mostly small coordinates
    function automatic t_pixel rand_pixel();
        t_pixel p;
        case ($urandom_range(0, 3))
            0: begin
                p.x = PIXW'($urandom);
                p.y = PIXW'($urandom);
            end
            1: begin
                p.x = PIXW'(int'($urandom_range(0, 511)) - 256);
                p.y = PIXW'(int'($urandom_range(0, 511)) - 256);
            end
            default: begin
                p.x = PIXW'(int'($urandom_range(0, 8191)) - 4096);
                p.y = PIXW'(int'($urandom_range(0, 8191)) - 4096);
            end
        endcase
        return p;
    endfunction

    task automatic queue_random(int n);
        repeat (n) pending_pixels.push_back(rand_pixel());
    endtask

    initial begin
        i_rst_n       = 1'b0;
        pix_ch.valid  = 1'b0;
        pix_ch.pixel_x = '0;
        pix_ch.pixel_y = '0;
        cube_ch.ready = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        radius_m = RADIUS_RST;
        origin_x_m = '0; origin_y_m = '0; offset_x_m = '0; offset_y_m = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes under reset defaults
        pending_pixels.push_back('{16'sh7fff, 16'sh7fff});
        pending_pixels.push_back('{16'sh8000, 16'sh8000});
        pending_pixels.push_back('{16'sh7fff, 16'sh8000});
        pending_pixels.push_back('{16'sh8000, 16'sh7fff});
        pending_pixels.push_back('{16'sh0000, 16'sh0000});
        pending_pixels.push_back('{16'sh0001, 16'shffff});
        pending_pixels.push_back('{16'sh0020, 16'sh0000});
        pending_pixels.push_back('{16'sh0000, 16'sh0018});
        drain();

        // Zero hex radius and a small radius: saturation
        write_reg(CFG_RADIUS, '0);
        pending_pixels.push_back('{16'sh7fff, 16'sh8000});
        pending_pixels.push_back('{16'sh0001, 16'sh0001});
        pending_pixels.push_back('{16'sh8000, 16'sh1234});
        drain();
        write_reg(CFG_RADIUS, CFG_DATAW'(7));
        pending_pixels.push_back('{16'sh4000, 16'shc000});
        pending_pixels.push_back('{16'sh0003, 16'sh0005});
        drain();

        // Unused register index: ignored by the block
        write_reg(t_cfg_idx'(3'd7), 21'h1fffff);
        write_reg(t_cfg_idx'(3'd5), 21'h0abcde);

        // Extreme origins and offsets
        write_all(12'd4095, 21'h0fffff, 21'h100000, 21'h100000, 21'h0fffff);
        pending_pixels.push_back('{16'sh7fff, 16'sh8000});
        pending_pixels.push_back('{16'sh8000, 16'sh7fff});
        pending_pixels.push_back('{16'sh0000, 16'sh0000});
        drain();
        write_all(12'd16, 21'h100000, 21'h0fffff, 21'h0fffff, 21'h100000);
        pending_pixels.push_back('{16'sh0000, 16'sh0000});
        pending_pixels.push_back('{16'sh0100, 16'shff00});
        drain();

        // Random phases across register settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_all(12'd512, '0, '0, '0, '0);
                1: write_all(12'd4095, 21'($urandom), 21'($urandom), 21'($urandom),
                             21'($urandom));
                2: write_all(12'd16, 21'($urandom), 21'($urandom), 21'($urandom),
                             21'($urandom));
                3: write_all(12'($urandom_range(0, 15)), 21'($urandom), 21'($urandom),
                             21'($urandom), 21'($urandom));
                default: write_all(12'($urandom_range(16, 4095)), 21'($urandom),
                                   21'($urandom), 21'($urandom), 21'($urandom));
            endcase
            if (ph == 2) begin
                // Long receiver hold-off while the sender keeps offering
                holdoff_left = 300;
                queue_random(120);
            end
            queue_random(220);
            drain();
        end

        $display("Covered %0d pixel transactions and %0d cube results over 13 register settings,",
                 accepted_in, accepted_out);
        $display("including zero and small sizes, extreme offsets and a long output stall.");
        if (mismatch_cnt == 0 && expected_cubes.size() == 0) begin
            $display("tb_pixel_to_hex_cube_round passed");
        end else begin
            $display("tb_pixel_to_hex_cube_round failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== pixel_to_hex_cube_round.f =====
+incdir+rtl
rtl/phcr_pkg.sv
rtl/phcr_ifs.sv
rtl/phcr_div_cell.sv
rtl/phcr_round.sv
rtl/pixel_to_hex_cube_round.sv
verif/tb_pixel_to_hex_cube_round.sv
